@@ design/rdc_pkg.sv @@
// rdc_pkg: shared constants, types and the digit character function
// of the radix digit converter; used by every module of the block
// no dependencies
`default_nettype none

package rdc_pkg;

	localparam int MAX_DIGITS_DEF   = 32;
	localparam int NUMBER_WIDTH_DEF = 32;

	localparam int VALUE_W = 32;
	localparam int RADIX_W = 9;
	localparam int DIGIT_W = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;

	localparam logic [DIGIT_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [DIGIT_W-1:0] CH_A     = 8'h41;
	localparam logic [DIGIT_W-1:0] DEC_BASE = 8'd10;

	// divider status seen by the sequencer
	typedef struct packed {
		logic done;       // one-cycle pulse, quotient and remainder ready
		logic quot_zero;  // quotient of the finished division is zero
	} rdc_div_stat_t;

	// '0'+d below ten, otherwise low 8 bits of 'A'+d-10
	function automatic logic [DIGIT_W-1:0] digit_char_f(input logic [DIGIT_W-1:0] d);
		if (d < DEC_BASE) begin
			return CH_ZERO + d;
		end else begin
			return CH_A + d - DEC_BASE;
		end
	endfunction

endpackage

`default_nettype wire

@@ design/rdc_divider.sv @@
// rdc_divider: bit-serial restoring divider, one quotient bit per cycle
// divides a NUMBER_WIDTH-bit value by a 9-bit base; uses rdc_pkg
`default_nettype none

module rdc_divider import rdc_pkg::*; #(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [NUMBER_WIDTH-1:0] dividend,
	input  wire logic [RADIX_W-1:0]      radix,
	output      logic [NUMBER_WIDTH-1:0] quotient,
	output      logic [DIGIT_W-1:0]      remainder,
	output      rdc_div_stat_t           stat
);

	localparam int BW = $clog2(NUMBER_WIDTH);

	logic [NUMBER_WIDTH-1:0] quot_q;
	logic [DIGIT_W-1:0]      rem_q;
	logic [BW-1:0]           bit_cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [RADIX_W-1:0] trial;
	logic               ge;
	logic [RADIX_W-1:0] rem_next;

	// remainder stays below the base, so it fits in 8 bits
	assign trial    = {rem_q, quot_q[NUMBER_WIDTH-1]};
	assign ge       = (trial >= radix);
	assign rem_next = ge ? (trial - radix) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= BW'(NUMBER_WIDTH - 1);
			end else if (busy_q) begin
				bit_cnt_q <= bit_cnt_q - 1'b1;
				if (bit_cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUMBER_WIDTH-2:0], ge};
			rem_q  <= rem_next[DIGIT_W-1:0];
		end
	end

	assign quotient       = quot_q;
	assign remainder      = rem_q;
	assign stat.done      = done_q;
	assign stat.quot_zero = (quot_q == '0);

endmodule

`default_nettype wire

@@ design/rdc_digit_store.sv @@
// rdc_digit_store: digit memory, one write and one registered read a cycle
// holds remainders least significant first; uses rdc_pkg
`default_nettype none

module rdc_digit_store import rdc_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(MAX_DIGITS)-1:0] wr_addr,
	input  wire logic [DIGIT_W-1:0]            wr_data,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(MAX_DIGITS)-1:0] rd_addr,
	output      logic [DIGIT_W-1:0]            rd_data
);

	logic [DIGIT_W-1:0] mem_q [MAX_DIGITS];
	logic [DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ design/radix_digit_converter.sv @@
// radix_digit_converter: top level, sequencer and output register
// uses rdc_pkg, rdc_divider, rdc_digit_store
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the 9-bit radix (reset 10); cfg_ready
//   is always high. Write it only while the block is idle.
//   s_tdata carries the 32-bit value; only its low NUMBER_WIDTH bits count.
//   One input item is taken at a time: s_tready is high only when idle.
//   Each digit leaves as one item on the m_ channel, most significant first,
//   m_tlast on the least significant digit. A radix outside 2..256 gives one
//   item with m_tuser set and m_tdata, m_tlast zero.
// Operation:
//   each division runs in the bit-serial divider, one quotient bit a cycle;
//   digits are then read back from the digit memory, each passing a read
//   state and then a load state into the output register. A zero value
//   skips the divider and stores a single zero digit; a bad radix goes
//   straight to the error state.
// Reset clears the sequencer, output valid and sets the radix to 10.
// A stalled receiver holds the output register; the sequencer waits and
// takes no new item until the last digit has entered the output register.
`default_nettype none

module radix_digit_converter import rdc_pkg::*; #(
	parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [RADIX_W-1:0] cfg_data,   // radix
	input  wire logic               s_tvalid,
	output      logic               s_tready,
	input  wire logic [VALUE_W-1:0] s_tdata,    // value_in
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [15:0]        m_tdata,    // digit_char [7:0], digit_value [15:8]
	output      logic               m_tlast,    // last_digit
	output      logic               m_tuser     // bad_radix
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_RD, ST_LOAD, ST_ERR} state_t;

	state_t             state_q;
	logic [RADIX_W-1:0] radix_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      rd_idx_q;

	logic [NUMBER_WIDTH-1:0] value_w;
	logic [NUMBER_WIDTH-1:0] div_quot;
	logic [DIGIT_W-1:0]      div_rem;
	rdc_div_stat_t           div_stat;
	logic                    div_start;
	logic [NUMBER_WIDTH-1:0] div_dividend;

	logic               accept;
	logic               radix_ok;
	logic               value_zero;
	logic               slot_free;
	logic               out_load;
	logic               div_last;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [DIGIT_W-1:0] wr_data;
	logic               rd_en;
	logic [DIGIT_W-1:0] rd_data;

	generate
		if (NUMBER_WIDTH <= VALUE_W) begin : g_trunc
			assign value_w = s_tdata[NUMBER_WIDTH-1:0];
		end else begin : g_ext
			assign value_w = {{(NUMBER_WIDTH-VALUE_W){1'b0}}, s_tdata};
		end
	endgenerate

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign radix_ok   = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
	assign value_zero = (value_w == '0);
	assign slot_free  = !m_tvalid || m_tready;
	assign out_load   = slot_free && (state_q == ST_LOAD || state_q == ST_ERR);

	// conversion ends when the quotient runs out or the store is full
	assign div_last = div_stat.quot_zero || (cnt_q == CW'(MAX_DIGITS - 1));

	assign div_start    = (accept && radix_ok && !value_zero) ||
	                      (state_q == ST_DIV && div_stat.done && !div_last);
	assign div_dividend = (state_q == ST_IDLE) ? value_w : div_quot;

	// zero input stores a single zero digit
	assign wr_en   = (accept && radix_ok && value_zero) ||
	                 (state_q == ST_DIV && div_stat.done);
	assign wr_addr = (state_q == ST_IDLE) ? '0 : cnt_q[AW-1:0];
	assign wr_data = (state_q == ST_IDLE) ? '0 : div_rem;
	assign rd_en   = (state_q == ST_RD);

	rdc_divider #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.radix    (radix_q),
		.quotient (div_quot),
		.remainder(div_rem),
		.stat     (div_stat)
	);

	rdc_digit_store #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			m_tuser  <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!radix_ok) begin
							cnt_q   <= '0;
							state_q <= ST_ERR;
						end else if (value_zero) begin
							cnt_q    <= CW'(1);
							rd_idx_q <= '0;
							state_q  <= ST_RD;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (div_last) begin
							rd_idx_q <= cnt_q[AW-1:0];
							state_q  <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (slot_free) begin
						m_tdata  <= {rd_data, digit_char_f(rd_data)};
						m_tlast  <= (rd_idx_q == '0);
						m_tuser  <= 1'b0;
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_RD;
						end
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						m_tdata  <= '0;
						m_tlast  <= 1'b0;
						m_tuser  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/rdc_checker.sv @@
// rdc_checker: port-level assertions for the radix digit converter
// uses rdc_pkg; bound to radix_digit_converter at the end of this file
`default_nettype none

module rdc_checker import rdc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [15:0]        m_tdata,
	input wire logic               m_tlast,
	input wire logic               m_tuser
);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	// error item carries no digit and no last mark
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("error item with digit fields set");

	// digit character agrees with digit value
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == digit_char_f(m_tdata[15:8]))
		else $error("digit character does not match value");

	// one item at a time: after an accept the input side closes
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("input ready right after an accept");

	// a stalled output item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tlast) && $stable(m_tuser))
		else $error("stalled output item changed");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

`default_nettype wire
